// File: design/smlc_pkg.sv
// ============================================================================
// smlc_pkg: shared types and constants for the sub-rectangle level counter
// Field widths, register indexes, register reset values and the per-cell
// control bundle that the top level broadcasts down the row of cells.
// ============================================================================
package smlc_pkg;

    localparam int ValueW = 16;   // cell_value
    localparam int SideW  = 7;    // side_length register
    localparam int LevelW = 16;   // level register
    localparam int CountW = 23;   // rectangle_count
    localparam int OutTdataW = 24;  // rectangle_count padded to whole bytes

    // configuration register indexes
    localparam logic REG_SIDE  = 1'b0;
    localparam logic REG_LEVEL = 1'b1;

    localparam logic [SideW-1:0]  SIDE_RESET  = 7'd64;
    localparam logic [LevelW-1:0] LEVEL_RESET = 16'd100;

    // broadcast to every cell
    typedef struct packed {
        logic clear;  // zero run heights, kill any token
        logic ge;     // new cell value >= level
        logic gt;     // new cell value >  level
    } t_cell_ctrl;

endpackage

// File: design/smlc_cell.sv
// ============================================================================
// smlc_cell: one grid column of the run-height chain
// Holds both run heights of its column. A walk token enters from the right
// neighbor (or starts here when this column takes the new cell), picks up
// min(running min, height) for both masks and moves one cell left per clock.
// ============================================================================
module smlc_cell #(
    parameter int HW = 7,    // run height width
    parameter int SW = 14    // walk sum width
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  smlc_pkg::t_cell_ctrl  i_ctrl,
    input  logic                  i_sel,       // this column takes the new cell
    input  logic                  i_tok_valid,
    input  logic [HW-1:0]         i_cur_ge,
    input  logic [HW-1:0]         i_cur_gt,
    input  logic [SW-1:0]         i_sum_ge,
    input  logic [SW-1:0]         i_sum_gt,
    output logic                  o_tok_valid,
    output logic [HW-1:0]         o_cur_ge,
    output logic [HW-1:0]         o_cur_gt,
    output logic [SW-1:0]         o_sum_ge,
    output logic [SW-1:0]         o_sum_gt
);

    logic [HW-1:0] r_h_ge, r_h_gt;
    logic [HW-1:0] n_h_ge, n_h_gt;
    logic [HW-1:0] w_h_ge, w_h_gt;      // height seen by the walk this cycle
    logic [HW-1:0] w_in_ge, w_in_gt;
    logic [SW-1:0] w_in_sge, w_in_sgt;
    logic [HW-1:0] w_min_ge, w_min_gt;
    logic          w_in_valid;
    logic          r_tok_valid;
    logic [HW-1:0] r_cur_ge, r_cur_gt;
    logic [SW-1:0] r_sum_ge, r_sum_gt;

    always_comb begin
        n_h_ge = i_ctrl.ge ? r_h_ge + HW'(1) : '0;
        n_h_gt = i_ctrl.gt ? r_h_gt + HW'(1) : '0;
        w_h_ge = i_sel ? n_h_ge : r_h_ge;
        w_h_gt = i_sel ? n_h_gt : r_h_gt;

        // a fresh walk starts with an unbounded running min
        w_in_valid = i_sel | i_tok_valid;
        w_in_ge    = i_sel ? '1 : i_cur_ge;
        w_in_gt    = i_sel ? '1 : i_cur_gt;
        w_in_sge   = i_sel ? '0 : i_sum_ge;
        w_in_sgt   = i_sel ? '0 : i_sum_gt;

        w_min_ge = (w_h_ge < w_in_ge) ? w_h_ge : w_in_ge;
        w_min_gt = (w_h_gt < w_in_gt) ? w_h_gt : w_in_gt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clear) begin
            r_h_ge      <= '0;
            r_h_gt      <= '0;
            r_tok_valid <= 1'b0;
        end else begin
            r_tok_valid <= w_in_valid;
            if (i_sel) begin
                r_h_ge <= n_h_ge;
                r_h_gt <= n_h_gt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_valid) begin
            r_cur_ge <= w_min_ge;
            r_cur_gt <= w_min_gt;
            r_sum_ge <= w_in_sge + SW'(w_min_ge);
            r_sum_gt <= w_in_sgt + SW'(w_min_gt);
        end
    end

    assign o_tok_valid = r_tok_valid;
    assign o_cur_ge    = r_cur_ge;
    assign o_cur_gt    = r_cur_gt;
    assign o_sum_ge    = r_sum_ge;
    assign o_sum_gt    = r_sum_gt;

endmodule

// File: design/submatrix_min_level_counter_top.sv
// ============================================================================
// submatrix_min_level_counter_top: sub-rectangle minimum-level counter
// Counts the sub-rectangles of a square grid whose minimum equals a level,
// as (all cells >= level) minus (all cells > level), with a row of cells.
// ============================================================================
//
//  channel   dir  width  contents
//  s_axis    in   16     cell_value, row-major grid cells
//  m_axis    out  24     rectangle_count [22:0], zero [23]; one per grid
//  cfg       in   16     index 0 side_length [6:0], index 1 level [15:0]
//
//  A cell holds off the next cell until its walk is done: the walk token
//  moves one column left per clock through the cell chain, from the
//  column of the cell down to column 0 (the last cell of a grid also emits).
//  Reset (synchronous, i_rst_n low) clears heights, total and position and
//  loads side_length=64, level=100. A register write clears all but the output.
//  The result sits in an output register; a stalled m_axis side does not
//  block input until the next grid result is ready to be loaded.
//
module submatrix_min_level_counter_top #(
    parameter int MAX_SIDE = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [15:0] i_cfg_wdata,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] cell_value
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // [22:0] rectangle_count, [23] zero
);

    localparam int HW = $clog2(MAX_SIDE + 1);                 // run height
    localparam int SW = 2 * HW;                               // one walk sum
    localparam int CW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;  // position
    localparam int EW = (HW > smlc_pkg::SideW) ? HW : smlc_pkg::SideW;
    localparam int TW = (4 * HW > smlc_pkg::CountW) ? 4 * HW : smlc_pkg::CountW;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WALK = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [smlc_pkg::SideW-1:0]  r_side;
    logic [smlc_pkg::LevelW-1:0] r_level;
    logic [CW-1:0]               r_col, r_row;
    logic [TW-1:0]               r_total;
    logic [1:0]                  r_state;
    logic                        r_last;
    logic                        r_out_valid;
    logic [smlc_pkg::CountW-1:0] r_out_data;

    logic [EW-1:0]        w_side_ext;
    logic [EW-1:0]        w_eff_m1;     // effective side minus one
    logic                 w_accept;
    logic                 w_emit;
    logic                 w_col_end, w_row_end;
    smlc_pkg::t_cell_ctrl w_ctrl;

    // token links; entry k is the output of cell k, entry MAX_SIDE is idle
    logic          w_tok_v  [MAX_SIDE+1];
    logic [HW-1:0] w_cur_ge [MAX_SIDE+1];
    logic [HW-1:0] w_cur_gt [MAX_SIDE+1];
    logic [SW-1:0] w_sum_ge [MAX_SIDE+1];
    logic [SW-1:0] w_sum_gt [MAX_SIDE+1];
    logic [MAX_SIDE-1:0] w_tok_vec;

    // side length 0 acts as 1, above MAX_SIDE saturates
    always_comb begin
        w_side_ext = EW'(r_side);
        if (w_side_ext == '0) begin
            w_eff_m1 = '0;
        end else if (w_side_ext > EW'(MAX_SIDE)) begin
            w_eff_m1 = EW'(MAX_SIDE - 1);
        end else begin
            w_eff_m1 = w_side_ext - EW'(1);
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid & s_axis_tready;
    assign w_col_end     = (EW'(r_col) == w_eff_m1);
    assign w_row_end     = (EW'(r_row) == w_eff_m1);
    assign w_emit        = (r_state == ST_EMIT) & (~r_out_valid | m_axis_tready);

    always_comb begin
        w_ctrl.clear = i_cfg_we | w_emit;
        w_ctrl.ge    = (s_axis_tdata >= r_level);
        w_ctrl.gt    = (s_axis_tdata >  r_level);
    end

    // ---- chain of column cells ----
    assign w_tok_v[MAX_SIDE]  = 1'b0;
    assign w_cur_ge[MAX_SIDE] = '0;
    assign w_cur_gt[MAX_SIDE] = '0;
    assign w_sum_ge[MAX_SIDE] = '0;
    assign w_sum_gt[MAX_SIDE] = '0;

    for (genvar k = 0; k < MAX_SIDE; k++) begin : g_cell
        smlc_cell #(
            .HW (HW),
            .SW (SW)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (w_ctrl),
            .i_sel       (w_accept && (r_col == CW'(k))),
            .i_tok_valid (w_tok_v[k+1]),
            .i_cur_ge    (w_cur_ge[k+1]),
            .i_cur_gt    (w_cur_gt[k+1]),
            .i_sum_ge    (w_sum_ge[k+1]),
            .i_sum_gt    (w_sum_gt[k+1]),
            .o_tok_valid (w_tok_v[k]),
            .o_cur_ge    (w_cur_ge[k]),
            .o_cur_gt    (w_cur_gt[k]),
            .o_sum_ge    (w_sum_ge[k]),
            .o_sum_gt    (w_sum_gt[k])
        );
        assign w_tok_vec[k] = w_tok_v[k];
    end

    // ---- configuration registers ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side  <= smlc_pkg::SIDE_RESET;
            r_level <= smlc_pkg::LEVEL_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                smlc_pkg::REG_SIDE:  r_side  <= i_cfg_wdata[smlc_pkg::SideW-1:0];
                smlc_pkg::REG_LEVEL: r_level <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // ---- grid position, total and sequencer ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_col   <= '0;
            r_row   <= '0;
            r_total <= '0;
            r_last  <= 1'b0;
            r_state <= ST_IDLE;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_state <= ST_WALK;
                        r_last  <= w_col_end & w_row_end;
                        if (w_col_end) begin
                            r_col <= '0;
                            r_row <= w_row_end ? '0 : r_row + CW'(1);
                        end else begin
                            r_col <= r_col + CW'(1);
                        end
                    end
                end
                ST_WALK: begin
                    // token has left column 0: both walk sums are complete
                    if (w_tok_v[0]) begin
                        r_total <= r_total + TW'(w_sum_ge[0]) - TW'(w_sum_gt[0]);
                        r_state <= r_last ? ST_EMIT : ST_IDLE;
                    end
                end
                ST_EMIT: begin
                    if (w_emit) begin
                        r_total <= '0;
                        r_last  <= 1'b0;
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // ---- output register ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_data <= r_total[smlc_pkg::CountW-1:0];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(smlc_pkg::OutTdataW - smlc_pkg::CountW){1'b0}}, r_out_data};

`ifndef SYNTH
    // at most one walk in flight along the chain
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_tok_vec))
        else $error("more than one walk token in the cell chain");

    // a token leaves column 0 only while the sequencer waits for it
    a_tok_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tok_v[0] |-> (r_state == ST_WALK))
        else $error("walk finished outside the walk state");

    // an accepted cell always starts a walk
    a_accept_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !i_cfg_we) |=> (r_state == ST_WALK) && w_tok_vec != '0)
        else $error("accepted transfer did not start a walk");

    // the result is emitted only with the grid position wrapped to the origin
    a_emit_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_col == '0) && (r_row == '0))
        else $error("grid result pending with position not at origin");
`endif

endmodule

// File: tb/submatrix_min_level_counter_top_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// submatrix_min_level_counter_top_tb: self-checking bench for the level counter
// Streams square grids into the block and checks every per-grid rectangle
// count against an in-bench predictor of the two run-height masks.
// ============================================================================
module submatrix_min_level_counter_top_tb;

    localparam int MAX_SIDE     = 64;
    localparam int DRAIN_CYCLES = 100;   // outlasts the walk of a cell in the last column
    localparam int RANDOM_CELLS = 1480;

    // ------------------------------------------------------------------------
    // Predictor and store of expected counts. Mirrors register writes and every
    // accepted cell; pushes a count when a cell closes a grid.
    // ------------------------------------------------------------------------
    class rect_count_board;
        int unsigned                 side_reg;
        int unsigned                 level_reg;
        int unsigned                 run_ge[MAX_SIDE];    // run heights of cells >= level
        int unsigned                 run_gt[MAX_SIDE];    // run heights of cells >  level
        longint unsigned             total;
        int unsigned                 col;
        int unsigned                 row;
        logic [smlc_pkg::CountW-1:0] pending_counts[$];
        int unsigned                 fails;

        function new();
            side_reg  = smlc_pkg::SIDE_RESET;
            level_reg = smlc_pkg::LEVEL_RESET;
            fails     = 0;
            clear();
        endfunction

        function void clear();
            foreach (run_ge[i]) begin
                run_ge[i] = 0;
                run_gt[i] = 0;
            end
            total = 0;
            col   = 0;
            row   = 0;
        endfunction

        function void write_reg(logic addr, logic [15:0] data);
            if (addr == smlc_pkg::REG_SIDE) begin
                side_reg = data[smlc_pkg::SideW-1:0];
            end else begin
                level_reg = data[smlc_pkg::LevelW-1:0];
            end
            clear();
        endfunction

        // side in use: zero acts as one, oversize clamps to MAX_SIDE
        function int unsigned span();
            if (side_reg == 0) return 1;
            if (side_reg > MAX_SIDE) return MAX_SIDE;
            return side_reg;
        endfunction

        // running minimum summed leftward from column c until it hits zero
        function longint unsigned walk(bit above, int unsigned c);
            longint unsigned sum;
            int unsigned     cur;
            int unsigned     h;
            int              k;
            sum = 0;
            cur = above ? run_gt[c] : run_ge[c];
            for (k = int'(c); k >= 0 && cur > 0; k--) begin
                h = above ? run_gt[k] : run_ge[k];
                if (h < cur) cur = h;
                sum += cur;
            end
            return sum;
        endfunction

        function void take_cell(logic [smlc_pkg::ValueW-1:0] v);
            int unsigned lim;
            lim = span();
            if (col >= lim) clear();
            run_ge[col] = (v >= level_reg) ? run_ge[col] + 1 : 0;
            run_gt[col] = (v >  level_reg) ? run_gt[col] + 1 : 0;
            total = total + walk(1'b0, col) - walk(1'b1, col);
            if (col + 1 < lim) begin
                col++;
            end else begin
                col = 0;
                if (row + 1 < lim) begin
                    row++;
                end else begin
                    pending_counts.push_back(total[smlc_pkg::CountW-1:0]);
                    clear();
                end
            end
        endfunction

        function void check_count(logic [smlc_pkg::CountW-1:0] got);
            logic [smlc_pkg::CountW-1:0] want;
            if (pending_counts.size() == 0) begin
                $error("rectangle_count: expected none, actual %0d", got);
                fails++;
            end else begin
                want = pending_counts.pop_front();
                if (got !== want) begin
                    $error("rectangle_count: expected %0d, actual %0d", want, got);
                    fails++;
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT signals, all inputs known from time zero
    // ------------------------------------------------------------------------
    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic        i_cfg_addr    = smlc_pkg::REG_SIDE;
    logic [15:0] i_cfg_wdata   = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;   // [15:0] cell_value
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;         // [22:0] rectangle_count, [23] zero

    logic        calm = 1'b0;          // suppresses idling on both sides
    int unsigned cells_sent = 0;

    rect_count_board board = new();

    submatrix_min_level_counter_top #(
        .MAX_SIDE(MAX_SIDE)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // Receiver: stalls ~30% of cycles unless calm.
    always @(posedge i_clk) begin
        m_axis_tready <= calm || ($urandom_range(99) >= 30);
    end

    // Monitor: everything the block sees or gives at this edge, pre-edge values.
    // Config writes and cell transfers never share an edge (writes wait for idle).
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) board.write_reg(i_cfg_addr, i_cfg_wdata);
            if (s_axis_tvalid && s_axis_tready)
                board.take_cell(s_axis_tdata[smlc_pkg::ValueW-1:0]);
            if (m_axis_tvalid && m_axis_tready)
                board.check_count(m_axis_tdata[smlc_pkg::CountW-1:0]);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus tasks
    // ------------------------------------------------------------------------

    // One cell transfer; random idle cycles ahead of it. tvalid stays high on
    // return so back-to-back cells need no extra assignment.
    task automatic send_cell(input logic [15:0] v);
        while (!calm && $urandom_range(99) < 30) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        do @(posedge i_clk); while (!s_axis_tready);
        cells_sent++;
    endtask

    // Stop sending, wait for every expected count, then idle `extra` clocks.
    // Always waits on a clock edge first so tvalid is never toggled in one step.
    task automatic settle(input int extra);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (board.pending_counts.size() != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    // Register write, only with the block idle (a partial grid may still be
    // walking its last cell, hence the drain).
    task automatic write_cfg(input logic addr, input logic [15:0] data);
        settle(DRAIN_CYCLES);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Cell values clustered around the level so both masks see long runs,
    // with some noise across the whole range.
    function automatic logic [15:0] pick_cell(int unsigned lvl);
        int v;
        case ($urandom_range(9))
            0, 1, 2: v = lvl;
            3, 4:    v = lvl + 1;
            5:       v = int'(lvl) - 1;
            6:       v = $urandom_range(65535);
            7:       v = 0;
            8:       v = 65535;
            default: v = lvl + $urandom_range(3);
        endcase
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return 16'(v);
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int unsigned side;
        int unsigned cells;
        int unsigned grids;
        int unsigned r;
        bit          first;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- directed: 1x1 grids against the reset level of 100
        write_cfg(smlc_pkg::REG_SIDE, 16'd1);
        send_cell(16'd100);
        send_cell(16'd99);
        send_cell(16'd101);
        send_cell(16'd0);
        send_cell(16'hFFFF);
        // side zero behaves as one
        write_cfg(smlc_pkg::REG_SIDE, 16'd0);
        send_cell(16'd100);
        // level extremes
        write_cfg(smlc_pkg::REG_LEVEL, 16'd0);
        send_cell(16'd0);
        send_cell(16'hFFFF);
        write_cfg(smlc_pkg::REG_LEVEL, 16'hFFFF);
        send_cell(16'hFFFF);
        send_cell(16'hFFFE);
        // 2x2 grids
        write_cfg(smlc_pkg::REG_SIDE, 16'd2);
        write_cfg(smlc_pkg::REG_LEVEL, 16'd5);
        send_cell(16'd5);
        send_cell(16'd5);
        send_cell(16'd5);
        send_cell(16'd5);
        send_cell(16'd5);
        send_cell(16'd6);
        send_cell(16'd7);
        send_cell(16'd5);
        // a write mid-grid discards the partial grid
        write_cfg(smlc_pkg::REG_SIDE, 16'd3);
        send_cell(16'd5);
        send_cell(16'd5);
        send_cell(16'd5);
        send_cell(16'd5);
        write_cfg(smlc_pkg::REG_SIDE, 16'd2);
        send_cell(16'd6);
        send_cell(16'd5);
        send_cell(16'd5);
        send_cell(16'd5);

        // --- side 127 saturates to MAX_SIDE: two full rows at the level wrap
        // the column at MAX_SIDE and walk the whole chain; no idling here.
        // The partial grid is dropped by the next register write.
        write_cfg(smlc_pkg::REG_SIDE, 16'hA5FF);
        write_cfg(smlc_pkg::REG_LEVEL, 16'($urandom_range(1, 65534)));
        calm <= 1'b1;
        for (int i = 0; i < 2 * MAX_SIDE; i++) send_cell(16'(board.level_reg));
        settle(0);
        calm <= 1'b0;

        // --- random: mostly complete small grids, with mid-grid rewrites
        cells_sent = 0;
        first      = 1'b1;
        while (cells_sent < RANDOM_CELLS) begin
            calm <= (cells_sent >= 600 && cells_sent < 900);
            if (first || $urandom_range(3) != 0) begin
                r    = $urandom_range(99);
                side = (r < 5) ? 0 : (r < 80) ? $urandom_range(1, 5) : $urandom_range(6, 10);
                write_cfg(smlc_pkg::REG_SIDE, {9'($urandom), 7'(side)});
            end
            if (first || $urandom_range(2) != 0) begin
                r = $urandom_range(19);
                write_cfg(smlc_pkg::REG_LEVEL, (r == 0) ? 16'd0 :
                                               (r == 1) ? 16'hFFFF :
                                               (r <  4) ? 16'($urandom_range(3)) :
                                                          16'($urandom));
            end
            cells = board.span() * board.span();
            grids = $urandom_range(1, 3);
            for (int g = 0; g < grids; g++) begin
                // hold off until the output side has caught up
                if (first || $urandom_range(7) == 0) settle(0);
                first = 1'b0;
                for (int i = 0; i < cells; i++) send_cell(pick_cell(board.level_reg));
            end
            // broken tail: a partial grid, left for the next write or next grid
            if (cells > 1 && $urandom_range(5) == 0) begin
                r = $urandom_range(1, cells - 1);
                for (int i = 0; i < r; i++) send_cell(pick_cell(board.level_reg));
            end
        end

        settle(DRAIN_CYCLES);
        if (board.fails == 0 && board.pending_counts.size() == 0) begin
            $display("submatrix_min_level_counter_top: match");
        end else begin
            $display("submatrix_min_level_counter_top: mismatch");
        end
        $finish;
    end

    // Watchdog, far above the slowest legal run.
    initial begin
        #(40_000_000);
        $display("submatrix_min_level_counter_top: mismatch");
        $finish;
    end

endmodule
